/* rtl/vaso_pkg.sv */
// shared types and constants of the oldest-steal voice allocator
// no dependencies; every other file of the block imports this package
package vaso_pkg;

  localparam int VOICES   = 9;
  localparam int AGE_BITS = 32;
  localparam int NOTE_W   = 7;
  localparam int MASK_W   = 9;
  localparam int CH_W     = 4;
  localparam int CNT_W    = $clog2(VOICES + 1);

  typedef logic [NOTE_W-1:0]   note_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [VOICES-1:0]   vmask_t;
  typedef logic [CH_W-1:0]     chan_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam age_t AGE_MAX = '1;

  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_e;

  // one event as held in the input stage
  typedef struct packed {
    op_e   op;
    note_t note;
  } evt_t;

  // one result transaction
  typedef struct packed {
    chan_t assigned_channel;
    logic  assigned_valid;
    logic  was_retrigger;
    logic  was_stolen;
    mask_t released_mask;
    cnt_t  active_count;
  } res_t;

endpackage

/* rtl/vaso_in_if.sv */
// event channel: valid/ready plus operation and note
// depends on vaso_pkg for field widths
interface vaso_in_if
  import vaso_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic  operation;
  note_t note;

  modport source (output valid, output operation, output note, input ready);
  modport sink   (input valid, input operation, input note, output ready);
endinterface

/* rtl/vaso_out_if.sv */
// result channel: valid/ready plus the allocation result fields
// depends on vaso_pkg for field widths
interface vaso_out_if
  import vaso_pkg::*;
  ();
  logic  valid;
  logic  ready;
  chan_t assigned_channel;
  logic  assigned_valid;
  logic  was_retrigger;
  logic  was_stolen;
  mask_t released_mask;
  cnt_t  active_count;

  modport source (output valid, output assigned_channel, output assigned_valid,
                  output was_retrigger, output was_stolen, output released_mask,
                  output active_count, input ready);
  modport sink   (input valid, input assigned_channel, input assigned_valid,
                  input was_retrigger, input was_stolen, input released_mask,
                  input active_count, output ready);
endinterface

/* rtl/vaso_cfg_if.sv */
// configuration write channel carrying the channel enable mask
// depends on vaso_pkg for the mask width
interface vaso_cfg_if
  import vaso_pkg::*;
  ();
  logic  valid;
  logic  ready;
  mask_t channel_enable_mask;

  modport source (output valid, output channel_enable_mask, input ready);
  modport sink   (input valid, input channel_enable_mask, output ready);
endinterface

/* rtl/vaso_table.sv */
// channel table: notes, busy flags, start stamps and a pairwise age order
// matrix, plus the pick logic for one event; depends on vaso_pkg
module vaso_table
  import vaso_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clear,
  input  mask_t enable_mask,
  input  evt_t  evt,
  input  logic  fire,
  output res_t  res
);

  logic  [VOICES-1:0]             busy_r, busy_nxt;
  note_t [VOICES-1:0]             note_r, note_nxt;
  age_t  [VOICES-1:0]             age_r, age_nxt;
  // older_r[i][j]: channel i ranks before channel j when stealing
  logic  [VOICES-1:0][VOICES-1:0] older_r, older_nxt;
  age_t                           stamp_r, stamp_nxt;

  vmask_t en, hit, free_ch, oldest, rel, sel;
  chan_t  pick;
  logic   any_en;
  cnt_t   cnt;

  // enable bits; channels beyond the mask are never enabled
  always_comb begin
    for (int c = 0; c < VOICES; c++) begin
      en[c] = (c < MASK_W) ? enable_mask[c] : 1'b0;
    end
  end

  // per-channel match, free and oldest flags
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      hit[i]     = en[i] & busy_r[i] & (note_r[i] == evt.note);
      free_ch[i] = en[i] & ~busy_r[i];
      rel[i]     = busy_r[i] & (note_r[i] == evt.note);
      oldest[i]  = en[i];
      for (int j = 0; j < VOICES; j++) begin
        if (j != i && en[j] && !older_r[i][j]) oldest[i] = 1'b0;
      end
    end
    any_en = |en;
  end

  // candidate set by priority, then lowest index among it
  always_comb begin
    if (|hit) sel = hit;
    else if (|free_ch) sel = free_ch;
    else sel = oldest;
    pick = '0;
    for (int c = VOICES - 1; c >= 0; c--) begin
      if (sel[c]) pick = CH_W'(c);
    end
  end

  // next table contents
  always_comb begin
    busy_nxt  = busy_r;
    note_nxt  = note_r;
    age_nxt   = age_r;
    stamp_nxt = stamp_r;
    case (evt.op)
      OP_NOTE_ON: begin
        if (any_en) begin
          busy_nxt[pick] = 1'b1;
          note_nxt[pick] = evt.note;
          age_nxt[pick]  = stamp_r;
          stamp_nxt      = (stamp_r == AGE_MAX) ? stamp_r : stamp_r + age_t'(1);
        end
      end
      OP_NOTE_OFF: begin
        for (int c = 0; c < VOICES; c++) begin
          if (rel[c]) begin
            busy_nxt[c] = 1'b0;
            note_nxt[c] = '0;
            age_nxt[c]  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // age order from the next stamps, ties to the lower index
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      for (int j = 0; j < VOICES; j++) begin
        if (i == j) older_nxt[i][j] = 1'b0;
        else older_nxt[i][j] = (age_nxt[i] < age_nxt[j]) ||
                               ((age_nxt[i] == age_nxt[j]) && (i < j));
      end
    end
  end

  // enabled busy channels after this event
  always_comb begin
    cnt = '0;
    for (int c = 0; c < VOICES; c++) begin
      cnt = cnt + cnt_t'(busy_nxt[c] & en[c]);
    end
  end

  // result fields
  always_comb begin
    res = '0;
    res.active_count = cnt;
    case (evt.op)
      OP_NOTE_ON: begin
        if (any_en) begin
          res.assigned_channel = pick;
          res.assigned_valid   = 1'b1;
          res.was_retrigger    = |hit;
          res.was_stolen       = ~(|hit) & ~(|free_ch);
        end
      end
      OP_NOTE_OFF: begin
        for (int c = 0; c < VOICES; c++) begin
          if (c < MASK_W) res.released_mask[c] = rel[c];
        end
      end
      default: begin
      end
    endcase
  end

  // table state; a mask write clears like reset
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      busy_r  <= '0;
      note_r  <= '0;
      age_r   <= '0;
      stamp_r <= age_t'(1);
      for (int i = 0; i < VOICES; i++) begin
        for (int j = 0; j < VOICES; j++) begin
          older_r[i][j] <= (i < j);
        end
      end
    end else if (fire) begin
      busy_r  <= busy_nxt;
      note_r  <= note_nxt;
      age_r   <= age_nxt;
      stamp_r <= stamp_nxt;
      older_r <= older_nxt;
    end
  end

endmodule

/* rtl/voice_allocator_steal_oldest_top.sv */
// top level of the oldest-steal voice allocator: handshake stages and mask
// register around vaso_table; depends on vaso_pkg and the channel interfaces

// Nine-channel polyphonic voice allocator. A note on goes to an enabled channel
// already holding the note, else the lowest free enabled channel, else the
// enabled channel started longest ago; a note off frees every channel holding
// the note. One event is taken per clock unless the output stalls; results wait
// in an output register until taken. The pace is set by the combinational pick
// and table update in vaso_table, which resolves steal order from a pairwise
// age matrix kept alongside the stamps. Writing the enable mask clears the
// table and the stamp counter; write it only while idle.
module voice_allocator_steal_oldest_top
  import vaso_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  vaso_in_if.sink    in_ch,
  vaso_out_if.source out_ch,
  vaso_cfg_if.sink   cfg_ch
);

  logic  s1_valid_r;
  evt_t  s1_evt_r;
  logic  out_valid_r;
  res_t  out_res_r;
  mask_t mask_r;
  res_t  res;
  logic  s1_fire;
  logic  cfg_fire;

  // handshake control
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign s1_fire      = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~s1_valid_r | s1_fire;

  // allocation table
  vaso_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_fire),
    .enable_mask (mask_r),
    .evt         (s1_evt_r),
    .fire        (s1_fire),
    .res         (res)
  );

  // enable mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
    end else if (cfg_fire) begin
      mask_r <= cfg_ch.channel_enable_mask;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_evt_r.op   <= op_e'(in_ch.operation);
      s1_evt_r.note <= in_ch.note;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  // result transaction outputs
  assign out_ch.valid            = out_valid_r;
  assign out_ch.assigned_channel = out_res_r.assigned_channel;
  assign out_ch.assigned_valid   = out_res_r.assigned_valid;
  assign out_ch.was_retrigger    = out_res_r.was_retrigger;
  assign out_ch.was_stolen       = out_res_r.was_stolen;
  assign out_ch.released_mask    = out_res_r.released_mask;
  assign out_ch.active_count     = out_res_r.active_count;

endmodule
